/* src/kpdc_pkg.sv */
// ----------------------------------------------------------------------------
// kpdc_pkg
// Shared types, register codes and helpers of the key press duration
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kpdc_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   localparam logic [CountWidth-1:0] ShortThresholdReset = 16'd50;
   localparam logic [CountWidth-1:0] MenuLongThresholdReset = 16'd2000;
   localparam logic [CountWidth-1:0] OtherLongThresholdReset = 16'd3000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SHORT_THRESHOLD = 2'd0,
      CSR_MENU_LONG_THRESHOLD = 2'd1,
      CSR_OTHER_LONG_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KEY_EVT_NONE = 2'd0,
      KEY_EVT_SHORT = 2'd1,
      KEY_EVT_LONG = 2'd2
   } key_event_type;

   typedef struct packed {
      logic [CountWidth-1:0] short_threshold;
      logic [CountWidth-1:0] menu_long_threshold;
      logic [CountWidth-1:0] other_long_threshold;
   } csr_type;

   typedef struct packed {
      logic menu_level;
      logic up_level;
      logic down_level;
      logic speed_level;
   } req_type;

   typedef struct packed {
      logic [1:0] menu_event;
      logic [1:0] up_event;
      logic [1:0] down_event;
      logic [1:0] speed_event;
   } rsp_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] value);
      logic [CountWidth-1:0] result;
      result = (value == CountMax) ? value : value + 1'b1;
      return result;
   endfunction

endpackage

`default_nettype wire

/* src/kpdc_plain_key.sv */
// ----------------------------------------------------------------------------
// kpdc_plain_key
// Hold counter of one plain key: count while held, classify on release.
// ----------------------------------------------------------------------------
`default_nettype none

module kpdc_plain_key (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   level,
   input  wire kpdc_pkg::csr_type      csr,
   output kpdc_pkg::key_event_type     key_event
);
   import kpdc_pkg::*;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   always_comb begin
      key_event = KEY_EVT_NONE;
      if (!level) begin
         count_in = sat_inc(count_ff);
      end else begin
         count_in = '0;
         if (count_ff > csr.other_long_threshold) begin
            key_event = KEY_EVT_LONG;
         end else if (count_ff > csr.short_threshold) begin
            key_event = KEY_EVT_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* src/kpdc_menu_key.sv */
// ----------------------------------------------------------------------------
// kpdc_menu_key
// Menu key tracker: short press armed while held and reported on release,
// long press reported while held, then locked until release.
// ----------------------------------------------------------------------------
`default_nettype none

module kpdc_menu_key (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   level,
   input  wire kpdc_pkg::csr_type      csr,
   output kpdc_pkg::key_event_type     key_event
);
   import kpdc_pkg::*;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  locked_ff;
   logic                  locked_in;
   logic                  armed_ff;
   logic                  armed_in;
   logic [CountWidth-1:0] count_inc;

   assign count_inc = sat_inc(count_ff);

   always_comb begin
      key_event = KEY_EVT_NONE;
      count_in = count_ff;
      locked_in = locked_ff;
      armed_in = armed_ff;
      if (level) begin
         count_in = '0;
         locked_in = 1'b0;
         armed_in = 1'b0;
         if (armed_ff) begin
            key_event = KEY_EVT_SHORT;
         end
      end else if (!locked_ff) begin
         count_in = count_inc;
         armed_in = armed_ff | (count_inc > csr.short_threshold);
         // long press wins over a short one armed in the same tick
         if (count_inc > csr.menu_long_threshold) begin
            count_in = '0;
            armed_in = 1'b0;
            locked_in = 1'b1;
            key_event = KEY_EVT_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         locked_ff <= 1'b0;
         armed_ff <= 1'b0;
      end else if (advance) begin
         count_ff <= count_in;
         locked_ff <= locked_in;
         armed_ff <= armed_in;
      end
   end

   a_locked_count_zero: assert property (@(posedge clock) disable iff (reset)
      locked_ff |-> (count_ff == '0))
      else $error("menu counter runs while locked");

   a_locked_not_armed: assert property (@(posedge clock) disable iff (reset)
      !(locked_ff && armed_ff))
      else $error("menu short press armed while locked");

   a_long_locks: assert property (@(posedge clock) disable iff (reset)
      (advance && key_event == KEY_EVT_LONG) |=> locked_ff)
      else $error("menu long press did not lock the key");

endmodule

`default_nettype wire

/* src/key_press_duration_classifier.sv */
// Output: a result is registered and appears in the cycle after its tick is transferred in.
// Throughput: one tick per cycle unless rsp_ready stalls; the result register frees
// as it is taken, so a new tick is taken while the previous result is being transferred out.
// Reset: synchronous; clears all counters, the menu lock and armed flag,
// empties the result register and restores the threshold registers.
// ----------------------------------------------------------------------------
// key_press_duration_classifier
// Top level: threshold registers, the four key trackers and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_duration_classifier (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire kpdc_pkg::req_type                        req_data,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output kpdc_pkg::rsp_type                             rsp_data,
   input  wire logic                                     csr_we,
   input  wire logic [kpdc_pkg::CsrIndexWidth-1:0]       csr_index,
   input  wire logic [kpdc_pkg::CsrDataWidth-1:0]        csr_wdata
);
   import kpdc_pkg::*;

   csr_type       csr_ff;
   logic          advance;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;
   key_event_type menu_event;
   key_event_type up_event;
   key_event_type down_event;
   key_event_type speed_event;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.short_threshold <= ShortThresholdReset;
         csr_ff.menu_long_threshold <= MenuLongThresholdReset;
         csr_ff.other_long_threshold <= OtherLongThresholdReset;
      end else if (csr_we) begin
         // drop writes to unknown indexes
         unique case (csr_index)
            CSR_SHORT_THRESHOLD: csr_ff.short_threshold <= csr_wdata;
            CSR_MENU_LONG_THRESHOLD: csr_ff.menu_long_threshold <= csr_wdata;
            CSR_OTHER_LONG_THRESHOLD: csr_ff.other_long_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

   kpdc_menu_key u_menu (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .level     (req_data.menu_level),
      .csr       (csr_ff),
      .key_event (menu_event)
   );

   kpdc_plain_key u_up (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .level     (req_data.up_level),
      .csr       (csr_ff),
      .key_event (up_event)
   );

   kpdc_plain_key u_down (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .level     (req_data.down_level),
      .csr       (csr_ff),
      .key_event (down_event)
   );

   kpdc_plain_key u_speed (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .level     (req_data.speed_level),
      .csr       (csr_ff),
      .key_event (speed_event)
   );

   always_comb begin
      rsp_data_in.menu_event = menu_event;
      rsp_data_in.up_event = up_event;
      rsp_data_in.down_event = down_event;
      rsp_data_in.speed_event = speed_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire
